// File: rtl/core/assert_macros.svh
// Assertion macros used by the refresh unit's control module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/crdr_pkg.sv
// Package: types, codes and the symbol ROM of the character LCD refresh unit.
`timescale 1ns / 1ps

package crdr_pkg;

  localparam logic OpTick  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [7:0]  CmdTop      = 8'h80;
  localparam logic [7:0]  CmdBottom   = 8'hC0;
  localparam logic [15:0] PeriodReset = 16'd150;
  localparam logic [7:0]  CharX       = 8'h58;
  localparam logic [7:0]  CharO       = 8'h4F;

  typedef struct packed {
    logic       op;
    logic [4:0] position;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       wanted_we;
    logic [7:0] wanted_code;
    logic       shown_we;
    logic [7:0] shown_code;
  } frame_wr_t;

  typedef struct packed {
    logic [7:0] wanted;
    logic [7:0] shown;
  } frame_rd_t;

  localparam logic [7:0] GlyphRom [256] = '{
    8'h20,8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,
    8'h07,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,
    8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h2D,8'h2E,8'h2F,
    8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
    8'h38,8'h39,8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,
    8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
    8'h48,8'h49,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,
    8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5A,8'h5B,8'h5C,8'h5D,8'h5E,8'h5F,
    8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,
    8'h68,8'h69,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,
    8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,
    8'h78,8'h79,8'h7A,8'h7B,8'h7C,8'h7D,8'hC5,8'h01,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'hA2,8'hB5,8'h20,8'h20,8'h20,8'h20,8'h20,8'h02,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h41,8'hA0,8'h42,8'hA1,8'hE0,8'h45,8'hA3,8'hA4,
    8'hA5,8'hA6,8'h4B,8'hA7,8'h4D,8'h48,8'h4F,8'hA8,
    8'h50,8'h43,8'h54,8'hA9,8'hAA,8'h58,8'hE1,8'hAB,
    8'hAC,8'hE2,8'hAD,8'hAE,8'hC4,8'hAF,8'hB0,8'hB1,
    8'h61,8'hB2,8'hB3,8'hB4,8'hE3,8'h65,8'hB6,8'hB7,
    8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'hBD,8'h6F,8'hBE,
    8'h70,8'h63,8'hBF,8'h79,8'hE4,8'h78,8'hE5,8'hC0,
    8'hC1,8'hE6,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7
  };

endpackage

// File: rtl/core/char_lcd_dirty_refresh_unit.sv
// Timing: a write transfer or a tick without reload completes in its accept cycle.
// A reloading tick reads the slot, compared in S_READ; if it changed, command and data
// bytes follow in S_CMD and then S_DATA, each held while the output is stalled.
// Throughput: one item a cycle in S_IDLE; the input stalls during a scan, paced by
// the frame read and the single output register. Reset: control state is cleared
// at once; the frame reset pattern comes from per-slot valid bits, no clearing pass.
`timescale 1ns / 1ps

module char_lcd_dirty_refresh_unit #(
  parameter int COLUMNS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crdr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crdr_pkg::out_item_t out_item_o
);
  import crdr_pkg::*;

  localparam int SlotW = $clog2(2 * COLUMNS);

  logic [15:0]      period_q;
  logic             rd_en;
  logic [SlotW-1:0] rd_slot, wanted_slot, shown_slot;
  frame_wr_t        frame_wr;
  frame_rd_t        frame_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  crdr_ctrl #(
    .Columns(COLUMNS),
    .SlotW  (SlotW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .period_i     (period_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .rd_en_o      (rd_en),
    .rd_slot_o    (rd_slot),
    .wanted_slot_o(wanted_slot),
    .shown_slot_o (shown_slot),
    .wr_o         (frame_wr),
    .rd_i         (frame_rd)
  );

  crdr_frame_mem #(
    .Columns(COLUMNS),
    .SlotW  (SlotW)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (rd_en),
    .rd_slot_i    (rd_slot),
    .wanted_slot_i(wanted_slot),
    .shown_slot_i (shown_slot),
    .wr_i         (frame_wr),
    .rd_o         (frame_rd)
  );

endmodule

// File: rtl/core/crdr_frame_mem.sv
// Wanted and shown frame memories with per-slot valid bits for the reset pattern.
`timescale 1ns / 1ps

module crdr_frame_mem #(
  parameter int Columns = 16,
  parameter int SlotW   = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [SlotW-1:0]    rd_slot_i,
  input  logic [SlotW-1:0]    wanted_slot_i,
  input  logic [SlotW-1:0]    shown_slot_i,
  input  crdr_pkg::frame_wr_t wr_i,
  output crdr_pkg::frame_rd_t rd_o
);
  import crdr_pkg::*;

  localparam int Slots = 2 * Columns;
  localparam logic ColOdd = (Columns % 2) == 1;

  logic [7:0] wanted_mem [Slots];
  logic [7:0] shown_mem  [Slots];
  logic [Slots-1:0] wanted_vld_q, shown_vld_q;
  logic [7:0] wanted_rd_q, shown_rd_q;
  logic [SlotW-1:0] rd_slot_q;
  logic bottom, col_odd;
  logic [7:0] wanted_rst, shown_rst;

  always_ff @(posedge clk_i) begin
    if (wr_i.wanted_we) begin
      wanted_mem[wanted_slot_i] <= wr_i.wanted_code;
    end
    if (rd_en_i) begin
      wanted_rd_q <= wanted_mem[rd_slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.shown_we) begin
      shown_mem[shown_slot_i] <= wr_i.shown_code;
    end
    if (rd_en_i) begin
      shown_rd_q <= shown_mem[rd_slot_i];
      rd_slot_q  <= rd_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_vld_q <= '0;
      shown_vld_q  <= '0;
    end else begin
      if (wr_i.wanted_we) begin
        wanted_vld_q[wanted_slot_i] <= 1'b1;
      end
      if (wr_i.shown_we) begin
        shown_vld_q[shown_slot_i] <= 1'b1;
      end
    end
  end

  // reset pattern: top XOXO.., bottom OXOX..; shown X on top, O below
  always_comb begin
    bottom     = rd_slot_q >= SlotW'(Columns);
    col_odd    = rd_slot_q[0] ^ (bottom & ColOdd);
    wanted_rst = (col_odd ^ bottom) ? CharO : CharX;
    shown_rst  = bottom ? CharO : CharX;
    rd_o.wanted = wanted_vld_q[rd_slot_q] ? wanted_rd_q : wanted_rst;
    rd_o.shown  = shown_vld_q[rd_slot_q] ? shown_rd_q : shown_rst;
  end

endmodule

// File: rtl/core/crdr_ctrl.sv
// Tick countdown, scan pointer, read-compare-write sequencer and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crdr_ctrl #(
  parameter int Columns = 16,
  parameter int SlotW   = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         period_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crdr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crdr_pkg::out_item_t out_item_o,
  output logic                rd_en_o,
  output logic [SlotW-1:0]    rd_slot_o,
  output logic [SlotW-1:0]    wanted_slot_o,
  output logic [SlotW-1:0]    shown_slot_o,
  output crdr_pkg::frame_wr_t wr_o,
  input  crdr_pkg::frame_rd_t rd_i
);
  import crdr_pkg::*;

  localparam int unsigned Slots = 2 * Columns;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMD  = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  logic [1:0]       st_q, st_d;
  logic [15:0]      cnt_q, cnt_d, cnt_dec;
  logic [SlotW-1:0] ptr_q, ptr_d, col;
  out_item_t        out_q, out_d;
  logic [7:0]       dbyte_q, dbyte_d;
  logic             accept, bottom;

  assign accept = in_valid_i && !in_stall_o;
  assign cnt_dec = cnt_q - 16'd1;
  assign bottom = ptr_q >= SlotW'(Columns);
  assign col = bottom ? ptr_q - SlotW'(Columns) : ptr_q;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    out_d   = out_q;
    dbyte_d = dbyte_q;
    in_stall_o    = 1'b1;
    rd_en_o       = 1'b0;
    rd_slot_o     = ptr_q;
    wanted_slot_o = SlotW'(in_item_i.position);
    shown_slot_o  = ptr_q;
    wr_o.wanted_we   = 1'b0;
    wr_o.wanted_code = in_item_i.char_code;
    wr_o.shown_we    = 1'b0;
    wr_o.shown_code  = rd_i.wanted;
    unique case (st_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          if (in_item_i.op == OpWrite) begin
            wr_o.wanted_we = 32'(in_item_i.position) < Slots;
          end else if (cnt_dec == '0) begin
            cnt_d   = period_i;
            rd_en_o = 1'b1;
            st_d    = S_READ;
          end else begin
            cnt_d = cnt_dec;
          end
        end
      end
      S_READ: begin
        ptr_d = (ptr_q == SlotW'(Slots - 1)) ? '0 : ptr_q + SlotW'(1);
        if (rd_i.wanted != rd_i.shown) begin
          wr_o.shown_we  = 1'b1;
          out_d.is_data  = 1'b0;
          out_d.bus_byte = (bottom ? CmdBottom : CmdTop) + 8'(col);
          out_d.last     = 1'b0;
          dbyte_d        = GlyphRom[rd_i.wanted];
          st_d           = S_CMD;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_CMD: begin
        if (!out_stall_i) begin
          out_d.is_data  = 1'b1;
          out_d.bus_byte = dbyte_q;
          out_d.last     = 1'b1;
          st_d           = S_DATA;
        end
      end
      S_DATA: begin
        if (!out_stall_i) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= PeriodReset;
      ptr_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    dbyte_q <= dbyte_d;
  end

  assign out_valid_o = (st_q == S_CMD) || (st_q == S_DATA);
  assign out_item_o  = out_q;

  `ASSERT_CLK(a_ptr_range, 32'(ptr_q) < Slots, "scan pointer beyond last slot")
  `ASSERT_CLK(a_read_follows_req, (st_q == S_READ) |-> $past(rd_en_o),
              "compare without a frame read")
  `ASSERT_CLK(a_pair_order,
              (out_valid_o && !out_stall_i && !out_item_o.last) |=>
              (out_valid_o && out_item_o.is_data && out_item_o.last),
              "command byte not followed by its data byte")

endmodule
